>>> sv/twis_pkg.sv
// Shared constants and request types for the trie word insert and search block.
`default_nettype none
package twis_pkg;

	localparam int NODES    = 1024;
	localparam int ALPHABET = 26;
	localparam int LETTER_W = 7;
	localparam int NODE_W   = $clog2(NODES);
	localparam int FREE_W   = $clog2(NODES + 1);
	localparam int SLOTS    = NODES * ALPHABET;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int OFF_W    = $clog2(ALPHABET);

	localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd97;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} link_req_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic              wdata;
		logic              re;
		logic [NODE_W-1:0] raddr;
	} end_req_t;

	typedef struct packed {
		logic              clearing;
		logic [FREE_W-1:0] free_node;
	} stat_t;

endpackage
`default_nettype wire

>>> sv/twis_in_if.sv
// Input channel carrying one letter word with its command and last mark.
`default_nettype none
interface twis_in_if
	import twis_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                command;
	logic [LETTER_W-1:0] letter;
	logic                last;

	modport source (output valid, output command, output letter, output last, input ready);
	modport sink (input valid, input command, input letter, input last, output ready);
endinterface
`default_nettype wire

>>> sv/twis_out_if.sv
// Output channel carrying one result word per finished word.
`default_nettype none
interface twis_out_if;
	logic valid;
	logic ready;
	logic found;
	logic overflow;

	modport source (output valid, output found, output overflow, input ready);
	modport sink (input valid, input found, input overflow, output ready);
endinterface
`default_nettype wire

>>> sv/twis_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module twis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/twis_walk.sv
// Walk sequencer: clearing pass, link lookup and allocation, end marks and result register.
`default_nettype none
module twis_walk
	import twis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	twis_in_if.sink                letters,
	twis_out_if.source             results,
	output      link_req_t         link_req,
	input  wire logic [NODE_W-1:0] link_rdata,
	output      end_req_t          end_req,
	input  wire logic              end_rdata,
	output      stat_t             stat
);

	typedef enum logic [1:0] {CLEAR, IDLE, LINK, RES} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [NODE_W-1:0]   cur_q;
	logic [FREE_W-1:0]   free_q;
	logic                miss_q;
	logic                fail_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic                out_overflow_q;

	logic                cmd_q;
	logic                last_q;
	logic                lval_q;
	logic [SLOT_W-1:0]   slot_q;

	logic                fire;
	logic [LETTER_W:0]   off_full;
	logic                lval;
	logic [OFF_W-1:0]    off;
	logic [SLOT_W-1:0]   slot;

	logic [NODE_W-1:0]   cur_n;
	logic [FREE_W-1:0]   free_n;
	logic                miss_n;
	logic                fail_n;
	logic                alloc;
	logic                res_load;
	logic                res_dead;

	assign letters.ready = (state_q == IDLE);
	assign fire          = letters.valid && letters.ready;

	assign off_full = {1'b0, letters.letter} - {1'b0, LETTER_BASE};
	assign lval     = (letters.letter >= LETTER_BASE)
		&& ({{(32 - LETTER_W - 1){1'b0}}, off_full} < 32'(ALPHABET));
	assign off      = lval ? off_full[OFF_W-1:0] : '0;
	assign slot     = SLOT_W'(cur_q) * SLOT_W'(ALPHABET) + SLOT_W'(off);

	assign res_dead = miss_q || fail_q;
	assign res_load = (state_q == RES) && (!out_valid_q || results.ready);

	always_comb begin
		cur_n  = cur_q;
		free_n = free_q;
		miss_n = miss_q;
		fail_n = fail_q;
		alloc  = 1'b0;
		if (!(miss_q || fail_q)) begin
			if (!lval_q) begin
				if (cmd_q == CMD_SEARCH) begin
					miss_n = 1'b1;
				end else begin
					fail_n = 1'b1;
				end
			end else if (link_rdata != '0) begin
				cur_n = link_rdata;
			end else if (cmd_q == CMD_SEARCH) begin
				miss_n = 1'b1;
			end else if (free_q < FREE_W'(NODES)) begin
				alloc  = 1'b1;
				cur_n  = free_q[NODE_W-1:0];
				free_n = free_q + FREE_W'(1);
			end else begin
				fail_n = 1'b1;
			end
		end
	end

	always_comb begin
		link_req       = '0;
		end_req        = '0;
		link_req.re    = fire;
		link_req.raddr = slot;
		case (state_q)
			CLEAR: begin
				link_req.we    = 1'b1;
				link_req.waddr = clr_q;
				end_req.we     = (clr_q < SLOT_W'(NODES));
				end_req.waddr  = clr_q[NODE_W-1:0];
			end
			LINK: begin
				link_req.we    = alloc;
				link_req.waddr = slot_q;
				link_req.wdata = free_q[NODE_W-1:0];
				end_req.re     = last_q && (cmd_q == CMD_SEARCH) && !(miss_n || fail_n);
				end_req.raddr  = cur_n;
			end
			RES: begin
				end_req.we     = res_load && (cmd_q == CMD_INSERT) && !res_dead;
				end_req.waddr  = cur_q;
				end_req.wdata  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= CLEAR;
			clr_q          <= '0;
			cur_q          <= '0;
			free_q         <= FREE_W'(1);
			miss_q         <= 1'b0;
			fail_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			out_found_q    <= 1'b0;
			out_overflow_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (fire) begin
						state_q <= LINK;
					end
				end
				LINK: begin
					cur_q   <= cur_n;
					free_q  <= free_n;
					miss_q  <= miss_n;
					fail_q  <= fail_n;
					state_q <= last_q ? RES : IDLE;
				end
				RES: begin
					if (res_load) begin
						out_found_q    <= (cmd_q == CMD_SEARCH) && !res_dead && end_rdata;
						out_overflow_q <= (cmd_q == CMD_INSERT) && res_dead;
						cur_q          <= '0;
						miss_q         <= 1'b0;
						fail_q         <= 1'b0;
						state_q        <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cmd_q  <= letters.command;
			last_q <= letters.last;
			lval_q <= lval;
			slot_q <= slot;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.found    = out_found_q;
	assign results.overflow = out_overflow_q;

	assign stat.clearing  = (state_q == CLEAR);
	assign stat.free_node = free_q;

endmodule
`default_nettype wire

>>> sv/trie_word_insert_search.sv
// Top level of the trie word insert and search block.
// Each letter word is accepted in IDLE with the link read, then LINK follows the link or
// allocates a node. A last letter then goes to RES for the end mark write and the result
// register load (a search reads its end mark in LINK); RES holds while an earlier result
// is not yet taken. The chain through the child-link memory read sets the rate. After
// reset a clearing pass zeroes both memories, and no letter is accepted until it ends.
`default_nettype none
module trie_word_insert_search
	import twis_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	twis_in_if.sink    letters,
	twis_out_if.source results
);

	link_req_t         link_req;
	end_req_t          end_req;
	logic [NODE_W-1:0] link_rdata;
	logic              end_rdata;
	stat_t             stat;

	twis_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.letters    (letters),
		.results    (results),
		.link_req   (link_req),
		.link_rdata (link_rdata),
		.end_req    (end_req),
		.end_rdata  (end_rdata),
		.stat       (stat)
	);

	twis_ram #(
		.WIDTH (NODE_W),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.re    (link_req.re),
		.raddr (link_req.raddr),
		.rdata (link_rdata)
	);

	twis_ram #(
		.WIDTH (1),
		.DEPTH (NODES)
	) u_end_ram (
		.clk   (clk),
		.we    (end_req.we),
		.waddr (end_req.waddr),
		.wdata (end_req.wdata),
		.re    (end_req.re),
		.raddr (end_req.raddr),
		.rdata (end_rdata)
	);

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.found && results.overflow))
		else $error("found and overflow raised together");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.free_node <= FREE_W'(NODES)) && (stat.free_node != '0))
		else $error("free node counter out of range");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !letters.ready)
		else $error("letter accepted during clearing pass");

	a_free_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.free_node != $past(stat.free_node))
		|-> (stat.free_node == FREE_W'($past(stat.free_node) + FREE_W'(1))))
		else $error("free node counter jumped");

	a_clear_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> (stat.free_node == FREE_W'(1)))
		else $error("node allocated before clearing pass ended");

endmodule
`default_nettype wire
